@@ design/sss_pkg.sv @@
// sss_pkg: shared types and constants of the scoped symbol stack
// item structs, opcode, status and sequencer state codes, parameter defaults
// no dependencies
`timescale 1ns / 1ps

package sss_pkg;

  // parameter defaults
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_SCOPES_DEF  = 16;
  localparam int KEY_BITS_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 16;

  // field widths fixed by the item format
  localparam int OPCODE_W = 3;
  localparam int NAME_W   = 64;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_OPEN     = 3'd0,
    OP_CLOSE    = 3'd1,
    OP_ADD      = 3'd2,
    OP_FIND_ALL = 3'd3,
    OP_FIND_IN  = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_TABLE_FULL  = 2'd1,
    ST_SCOPES_FULL = 2'd2,
    ST_NO_SCOPE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLOSE_LD,
    S_SEARCH,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [NAME_W-1:0]   name_key;
    logic [HANDLE_W-1:0] entry_handle;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] match_handle;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // result handoff from the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_item_t data;
  } res_t;

endpackage

@@ design/sss_entry_ram.sv @@
// sss_entry_ram: key and handle storage of the symbol entries
// one write port, one read port with registered read data
// depends on nothing but its parameters
`timescale 1ns / 1ps

module sss_entry_ram #(
  parameter int DEPTH       = 64,
  parameter int KEY_BITS    = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [KEY_BITS-1:0]      wr_key,
  input  logic [HANDLE_BITS-1:0]   wr_handle,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [KEY_BITS-1:0]      rd_key,
  output logic [HANDLE_BITS-1:0]   rd_handle
);

  logic [KEY_BITS-1:0]    key_mem [DEPTH];
  logic [HANDLE_BITS-1:0] hdl_mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      hdl_mem[wr_addr] <= wr_handle;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key    <= key_mem[rd_addr];
      rd_handle <= hdl_mem[rd_addr];
    end
  end

endmodule

@@ design/sss_count_ram.sv @@
// sss_count_ram: entry counts of the outer (saved) scopes
// one write port, one read port with registered read data
// depends on nothing but its parameters
`timescale 1ns / 1ps

module sss_count_ram #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 7
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [CNT_W-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [CNT_W-1:0]         rd_data
);

  logic [CNT_W-1:0] cnt_mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= cnt_mem[rd_addr];
    end
  end

endmodule

@@ design/sss_seq.sv @@
// sss_seq: sequencer of the scoped symbol stack with the shared key compare
// drives sss_entry_ram and sss_count_ram, hands results to the output register
// depends on sss_pkg
`timescale 1ns / 1ps

module sss_seq #(
  parameter int MAX_ENTRIES = sss_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_SCOPES  = sss_pkg::MAX_SCOPES_DEF,
  parameter int KEY_BITS    = sss_pkg::KEY_BITS_DEF,
  parameter int HANDLE_BITS = sss_pkg::HANDLE_BITS_DEF,
  localparam int IDX_W  = $clog2(MAX_ENTRIES),
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1),
  localparam int SIDX_W = $clog2(MAX_SCOPES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input item
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sss_pkg::in_item_t      in_data,
  // result handoff
  output sss_pkg::res_t          res,
  input  logic                   res_ready,
  // entry memory
  output logic                   ent_wr_en,
  output logic [IDX_W-1:0]       ent_wr_addr,
  output logic [KEY_BITS-1:0]    ent_wr_key,
  output logic [HANDLE_BITS-1:0] ent_wr_handle,
  output logic                   ent_rd_en,
  output logic [IDX_W-1:0]       ent_rd_addr,
  input  logic [KEY_BITS-1:0]    ent_rd_key,
  input  logic [HANDLE_BITS-1:0] ent_rd_handle,
  // scope count memory
  output logic                   cnt_wr_en,
  output logic [SIDX_W-1:0]      cnt_wr_addr,
  output logic [CNT_W-1:0]       cnt_wr_data,
  output logic                   cnt_rd_en,
  output logic [SIDX_W-1:0]      cnt_rd_addr,
  input  logic [CNT_W-1:0]       cnt_rd_data
);

  localparam int LVL_W = $clog2(MAX_SCOPES + 1);

  sss_pkg::seq_state_t state_r, state_nxt;

  // latched item
  logic [sss_pkg::OPCODE_W-1:0] op_r;
  logic [KEY_BITS-1:0]          key_r;
  logic [HANDLE_BITS-1:0]       hdl_r;

  // table state
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] cur_cnt_r, cur_cnt_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;

  // search walk
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             hit;

  // result fields
  logic                         found_r, found_nxt;
  logic [HANDLE_BITS-1:0]       match_r, match_nxt;
  logic [sss_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic accept;
  logic no_scope;
  logic [LVL_W-1:0] level_m1;
  logic [LVL_W-1:0] level_m2;

  assign accept   = in_valid && in_ready;
  assign no_scope = (level_r == '0);
  assign level_m1 = level_r - LVL_W'(1);
  assign level_m2 = level_r - LVL_W'(2);
  assign hit      = rd_vld_r && (ent_rd_key == key_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sss_pkg::S_IDLE: begin
        if (accept) state_nxt = sss_pkg::S_EXEC;
      end
      sss_pkg::S_EXEC: begin
        unique case (sss_pkg::opcode_t'(op_r))
          sss_pkg::OP_CLOSE: begin
            if (!no_scope && level_r >= LVL_W'(2)) state_nxt = sss_pkg::S_CLOSE_LD;
            else state_nxt = sss_pkg::S_RESP;
          end
          sss_pkg::OP_FIND_ALL, sss_pkg::OP_FIND_IN: begin
            state_nxt = no_scope ? sss_pkg::S_RESP : sss_pkg::S_SEARCH;
          end
          default: state_nxt = sss_pkg::S_RESP;
        endcase
      end
      sss_pkg::S_CLOSE_LD: state_nxt = sss_pkg::S_RESP;
      sss_pkg::S_SEARCH: begin
        if (hit || (remain_r == '0 && !rd_vld_r)) state_nxt = sss_pkg::S_RESP;
      end
      sss_pkg::S_RESP: begin
        if (res_ready) state_nxt = sss_pkg::S_IDLE;
      end
      default: state_nxt = sss_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    total_nxt   = total_r;
    cur_cnt_nxt = cur_cnt_r;
    level_nxt   = level_r;
    pos_nxt     = pos_r;
    remain_nxt  = remain_r;
    rd_vld_nxt  = 1'b0;
    found_nxt   = found_r;
    match_nxt   = match_r;
    status_nxt  = status_r;

    ent_wr_en     = 1'b0;
    ent_wr_addr   = total_r[IDX_W-1:0];
    ent_wr_key    = key_r;
    ent_wr_handle = hdl_r;
    ent_rd_en     = 1'b0;
    ent_rd_addr   = pos_r;
    cnt_wr_en     = 1'b0;
    cnt_wr_addr   = level_m1[SIDX_W-1:0];
    cnt_wr_data   = cur_cnt_r;
    cnt_rd_en     = 1'b0;
    cnt_rd_addr   = level_m2[SIDX_W-1:0];

    unique case (state_r)
      sss_pkg::S_IDLE: begin
        if (accept) begin
          found_nxt  = 1'b0;
          match_nxt  = '0;
          status_nxt = sss_pkg::ST_OK;
        end
      end
      sss_pkg::S_EXEC: begin
        unique case (sss_pkg::opcode_t'(op_r))
          sss_pkg::OP_OPEN: begin
            if (level_r >= LVL_W'(MAX_SCOPES)) begin
              status_nxt = sss_pkg::ST_SCOPES_FULL;
            end else begin
              // save the innermost count before starting an empty scope
              cnt_wr_en   = !no_scope;
              cur_cnt_nxt = '0;
              level_nxt   = level_r + LVL_W'(1);
            end
          end
          sss_pkg::OP_CLOSE: begin
            if (no_scope) begin
              status_nxt = sss_pkg::ST_NO_SCOPE;
            end else begin
              total_nxt   = (cur_cnt_r > total_r) ? '0 : total_r - cur_cnt_r;
              level_nxt   = level_m1;
              cnt_rd_en   = (level_r >= LVL_W'(2));
              cur_cnt_nxt = '0;
            end
          end
          sss_pkg::OP_ADD: begin
            if (no_scope) begin
              status_nxt = sss_pkg::ST_NO_SCOPE;
            end else if (total_r >= CNT_W'(MAX_ENTRIES)) begin
              status_nxt = sss_pkg::ST_TABLE_FULL;
            end else begin
              ent_wr_en   = 1'b1;
              total_nxt   = total_r + CNT_W'(1);
              cur_cnt_nxt = cur_cnt_r + CNT_W'(1);
            end
          end
          sss_pkg::OP_FIND_ALL, sss_pkg::OP_FIND_IN: begin
            if (no_scope) begin
              status_nxt = sss_pkg::ST_NO_SCOPE;
            end else begin
              // walk down from the newest entry
              remain_nxt = (sss_pkg::opcode_t'(op_r) == sss_pkg::OP_FIND_ALL)
                           ? total_r : cur_cnt_r;
              pos_nxt    = IDX_W'(total_r - CNT_W'(1));
            end
          end
          default: begin
          end
        endcase
      end
      sss_pkg::S_CLOSE_LD: begin
        // restore the count of the scope that is now innermost
        cur_cnt_nxt = cnt_rd_data;
      end
      sss_pkg::S_SEARCH: begin
        if (hit) begin
          found_nxt = 1'b1;
          match_nxt = ent_rd_handle;
        end else if (remain_r != '0) begin
          // one read issued per cycle, compared on the next
          ent_rd_en  = 1'b1;
          rd_vld_nxt = 1'b1;
          pos_nxt    = pos_r - IDX_W'(1);
          remain_nxt = remain_r - CNT_W'(1);
        end
      end
      sss_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // handshake outputs, input held off while in reset
  assign in_ready               = rst_n && (state_r == sss_pkg::S_IDLE);
  assign res.valid              = (state_r == sss_pkg::S_RESP);
  assign res.data.found         = found_r;
  assign res.data.match_handle  = sss_pkg::HANDLE_W'(match_r);
  assign res.data.status        = status_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sss_pkg::S_IDLE;
      total_r   <= '0;
      cur_cnt_r <= '0;
      level_r   <= LVL_W'(1);
      rd_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      cur_cnt_r <= cur_cnt_nxt;
      level_r   <= level_nxt;
      rd_vld_r  <= rd_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.opcode;
      key_r <= KEY_BITS'(in_data.name_key);
      hdl_r <= HANDLE_BITS'(in_data.entry_handle);
    end
    pos_r    <= pos_nxt;
    remain_r <= remain_nxt;
    found_r  <= found_nxt;
    match_r  <= match_nxt;
    status_r <= status_nxt;
  end

endmodule

@@ design/scoped_symbol_stack.sv @@
// Scoped symbol stack: a table of key/handle entries grouped into nested scopes.
// After reset one empty scope is open. Opcodes open a scope, close the innermost
// scope (dropping its entries), add an entry to the innermost scope, look a key up
// newest-first over all scopes, or over the innermost scope only; each item gives
// exactly one result with found, match_handle and status. One item is in work at a
// time. A close that reopens an outer scope passes through an extra state that reads
// back that scope's count. A lookup walks its entries newest-first and stops at the
// first hit or when none are left; the single read port of the entry memory feeds one
// key compare per cycle. out_valid rises in the same cycle as in_ready; the result
// waits in the output register while the next item is already accepted, and a result
// that is not drained holds the next one and blocks the input.
// depends on sss_pkg, sss_seq, sss_entry_ram, sss_count_ram
`timescale 1ns / 1ps

module scoped_symbol_stack #(
  parameter int MAX_ENTRIES = sss_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_SCOPES  = sss_pkg::MAX_SCOPES_DEF,
  parameter int KEY_BITS    = sss_pkg::KEY_BITS_DEF,
  parameter int HANDLE_BITS = sss_pkg::HANDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sss_pkg::out_item_t out_data
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SIDX_W = $clog2(MAX_SCOPES);

  sss_pkg::res_t      res;
  logic               res_ready;
  logic               out_valid_r;
  sss_pkg::out_item_t out_data_r;

  logic                   ent_wr_en, ent_rd_en;
  logic [IDX_W-1:0]       ent_wr_addr, ent_rd_addr;
  logic [KEY_BITS-1:0]    ent_wr_key, ent_rd_key;
  logic [HANDLE_BITS-1:0] ent_wr_handle, ent_rd_handle;
  logic                   cnt_wr_en, cnt_rd_en;
  logic [SIDX_W-1:0]      cnt_wr_addr, cnt_rd_addr;
  logic [CNT_W-1:0]       cnt_wr_data, cnt_rd_data;

  sss_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_SCOPES  (MAX_SCOPES),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .res           (res),
    .res_ready     (res_ready),
    .ent_wr_en     (ent_wr_en),
    .ent_wr_addr   (ent_wr_addr),
    .ent_wr_key    (ent_wr_key),
    .ent_wr_handle (ent_wr_handle),
    .ent_rd_en     (ent_rd_en),
    .ent_rd_addr   (ent_rd_addr),
    .ent_rd_key    (ent_rd_key),
    .ent_rd_handle (ent_rd_handle),
    .cnt_wr_en     (cnt_wr_en),
    .cnt_wr_addr   (cnt_wr_addr),
    .cnt_wr_data   (cnt_wr_data),
    .cnt_rd_en     (cnt_rd_en),
    .cnt_rd_addr   (cnt_rd_addr),
    .cnt_rd_data   (cnt_rd_data)
  );

  sss_entry_ram #(
    .DEPTH       (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_entry_ram (
    .clk       (clk),
    .wr_en     (ent_wr_en),
    .wr_addr   (ent_wr_addr),
    .wr_key    (ent_wr_key),
    .wr_handle (ent_wr_handle),
    .rd_en     (ent_rd_en),
    .rd_addr   (ent_rd_addr),
    .rd_key    (ent_rd_key),
    .rd_handle (ent_rd_handle)
  );

  sss_count_ram #(
    .DEPTH (MAX_SCOPES),
    .CNT_W (CNT_W)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/sss_checker.sv @@
// sss_checker: port-level assertions for scoped_symbol_stack, bound to the top level
// watches only the top-level ports
// depends on sss_pkg and scoped_symbol_stack
`timescale 1ns / 1ps

module sss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sss_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input sss_pkg::out_item_t out_data
);

  // an offered item holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted item");

  // a miss reports handle zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_handle == '0)
    else $error("handle nonzero without a match");

  // a hit is always a clean status
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == sss_pkg::ST_OK)
    else $error("match reported with an error status");

endmodule

bind scoped_symbol_stack sss_checker u_sss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
